FILE: design/cwa_pkg.sv
package cwa_pkg;

	localparam int ADC_W   = 10;
	localparam int DAC_W   = 12;
	localparam int PHASE_W = 16;
	localparam int REF_W   = 12;
	localparam int COEF_W  = 16;
	localparam int ERR_W   = 14;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int PC_W    = 4;
	localparam int ACC_W   = 32;
	localparam int FRAC_W  = 12;
	localparam int U_W     = ACC_W - FRAC_W;

	// register indexes on the configuration port
	typedef enum logic [IDX_W-1:0] {
		REG_PHASE_STEP = 3'd0,
		REG_REF_HIGH   = 3'd1,
		REG_COEF_B0    = 3'd2,
		REG_COEF_B1    = 3'd3,
		REG_COEF_B2    = 3'd4,
		REG_AWU_B0     = 3'd5,
		REG_AWU_B1     = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_SCALE,
		OP_ERROR,
		OP_MAC,
		OP_TRUNC,
		OP_BRANCH,
		OP_EMIT
	} op_t;

	// what the multiply-accumulate adds its product to
	typedef enum logic [1:0] {
		BASE_ACC,
		BASE_ZERO,
		BASE_U1,
		BASE_TRUNC
	} base_t;

	typedef enum logic [2:0] {
		CF_B0,
		CF_B1,
		CF_B2,
		CF_AB0,
		CF_AB1
	} coef_t;

	typedef enum logic [1:0] {
		ER_E,
		ER_E1,
		ER_E2
	} err_t;

	typedef struct packed {
		op_t             op;
		base_t           base;
		coef_t           coef;
		err_t            err;
		logic [PC_W-1:0] target;
	} ctrl_t;

	localparam logic [PC_W-1:0] PC_START = 4'd0;
	localparam logic [PC_W-1:0] PC_EMIT  = 4'd11;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{op: OP_WAIT, base: BASE_ACC, coef: CF_B0, err: ER_E, target: PC_START};
		case (pc)
			4'd0:  w.op = OP_WAIT;
			4'd1:  w.op = OP_SCALE;
			4'd2:  w.op = OP_ERROR;
			4'd3:  w = '{op: OP_MAC, base: BASE_U1, coef: CF_B1, err: ER_E1, target: PC_START};
			4'd4:  w = '{op: OP_MAC, base: BASE_ACC, coef: CF_B2, err: ER_E2, target: PC_START};
			4'd5:  w = '{op: OP_MAC, base: BASE_TRUNC, coef: CF_B0, err: ER_E, target: PC_START};
			4'd6:  w.op = OP_TRUNC;
			4'd7:  begin
				w.op = OP_BRANCH;
				w.target = PC_EMIT;
			end
			4'd8:  w = '{op: OP_MAC, base: BASE_ZERO, coef: CF_AB1, err: ER_E1, target: PC_START};
			4'd9:  w = '{op: OP_MAC, base: BASE_TRUNC, coef: CF_AB0, err: ER_E, target: PC_START};
			4'd10: w.op = OP_TRUNC;
			4'd11: begin
				w.op = OP_EMIT;
				w.target = PC_START;
			end
			default: w.op = OP_WAIT;
		endcase
		return w;
	endfunction

endpackage

FILE: design/cwa_in_if.sv
interface cwa_in_if;
	logic                       valid;
	logic                       ready;
	logic [cwa_pkg::ADC_W-1:0]  adc_sample;

	modport source(output valid, output adc_sample, input ready);
	modport sink(input valid, input adc_sample, output ready);
endinterface

FILE: design/cwa_out_if.sv
interface cwa_out_if;
	logic                       valid;
	logic                       ready;
	logic [cwa_pkg::DAC_W-1:0]  dac_value;
	logic                       windup_used;
	logic                       clamped;

	modport source(output valid, output dac_value, output windup_used, output clamped,
		input ready);
	modport sink(input valid, input dac_value, input windup_used, input clamped,
		output ready);
endinterface

FILE: design/compensator_with_anti_windup_top.sv
// sequence: an accepted sample runs the scale, error, MAC, truncate, branch and emit steps;
// the anti-windup law inserts MAC and truncate steps before emit (one microcode step per cycle)
// throughput: no new sample is accepted until its result word is emitted; the single shared
// multiply-accumulate serves every product; emit holds while the last word is unclaimed
// reset: arst_n clears phase, error and control history and loads the default registers
module compensator_with_anti_windup_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cwa_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cwa_pkg::CFG_W-1:0]     cfg_wdata,
	cwa_in_if.sink                        sample_ch,
	cwa_out_if.source                     result_ch
);

	logic [cwa_pkg::PC_W-1:0]           pc_q;
	cwa_pkg::ctrl_t                     cw;

	logic [cwa_pkg::PHASE_W-1:0]        phase_step_q;
	logic [cwa_pkg::REF_W-1:0]          ref_high_q;
	logic signed [cwa_pkg::COEF_W-1:0]  coef_b0_q, coef_b1_q, coef_b2_q;
	logic signed [cwa_pkg::COEF_W-1:0]  awu_b0_q, awu_b1_q;

	logic [cwa_pkg::PHASE_W-1:0]        phase_q;
	logic signed [cwa_pkg::ERR_W-1:0]   err_prev_q, err_prev2_q, err_q;
	logic [cwa_pkg::DAC_W-1:0]          ctrl_prev_q;

	logic [cwa_pkg::ADC_W-1:0]          adc_q;
	logic [14:0]                        scaled_q;
	logic signed [cwa_pkg::ACC_W-1:0]   acc_q;
	logic signed [cwa_pkg::U_W-1:0]     u_q;
	logic                               awu_q;

	logic                               out_valid_q;
	logic [cwa_pkg::DAC_W-1:0]          out_dac_q;
	logic                               out_awu_q;
	logic                               out_clip_q;

	logic [17:0]                        adc_x129;
	logic [30:0]                        div5_prod;
	logic [cwa_pkg::DAC_W-1:0]          y_val;
	logic [cwa_pkg::REF_W-1:0]          ref_val;
	logic signed [cwa_pkg::ERR_W-1:0]   err_new;
	logic signed [cwa_pkg::COEF_W-1:0]  coef_val;
	logic signed [cwa_pkg::ERR_W-1:0]   err_val;
	logic signed [29:0]                 prod;
	logic signed [cwa_pkg::ACC_W-1:0]   acc_adj;
	logic signed [cwa_pkg::U_W-1:0]     acc_trunc;
	logic signed [cwa_pkg::ACC_W-1:0]   acc_base;
	logic signed [cwa_pkg::ACC_W-1:0]   acc_next;
	logic                               u_in_range;
	logic [cwa_pkg::DAC_W-1:0]          u_clamped;
	logic                               emit_blocked;

	assign cw = cwa_pkg::ucode(pc_q);

	assign sample_ch.ready       = (cw.op == cwa_pkg::OP_WAIT);
	assign result_ch.valid       = out_valid_q;
	assign result_ch.dac_value   = out_dac_q;
	assign result_ch.windup_used = out_awu_q;
	assign result_ch.clamped     = out_clip_q;

	// y = floor(adc * 129 / 40): shift out the 8, then divide by 5 via reciprocal
	assign adc_x129  = {1'b0, adc_q, 7'b0} + {8'b0, adc_q};
	assign div5_prod = 31'(scaled_q) * 31'd52429;
	assign y_val     = div5_prod[29:18];
	assign ref_val   = phase_q[cwa_pkg::PHASE_W-1] ? ref_high_q : '0;
	assign err_new   = $signed({2'b00, ref_val}) - $signed({2'b00, y_val});

	always_comb begin
		case (cw.coef)
			cwa_pkg::CF_B0:  coef_val = coef_b0_q;
			cwa_pkg::CF_B1:  coef_val = coef_b1_q;
			cwa_pkg::CF_B2:  coef_val = coef_b2_q;
			cwa_pkg::CF_AB0: coef_val = awu_b0_q;
			cwa_pkg::CF_AB1: coef_val = awu_b1_q;
			default:         coef_val = coef_b0_q;
		endcase
		case (cw.err)
			cwa_pkg::ER_E:  err_val = err_q;
			cwa_pkg::ER_E1: err_val = err_prev_q;
			cwa_pkg::ER_E2: err_val = err_prev2_q;
			default:        err_val = err_q;
		endcase
	end

	assign prod = coef_val * err_val;

	// divide by 4096 rounding toward zero
	assign acc_adj   = acc_q[cwa_pkg::ACC_W-1] ? (acc_q + 32'sd4095) : acc_q;
	assign acc_trunc = acc_adj[cwa_pkg::ACC_W-1:cwa_pkg::FRAC_W];

	always_comb begin
		case (cw.base)
			cwa_pkg::BASE_ACC:   acc_base = acc_q;
			cwa_pkg::BASE_ZERO:  acc_base = '0;
			cwa_pkg::BASE_U1:    acc_base = $signed({8'b0, ctrl_prev_q, 12'b0});
			cwa_pkg::BASE_TRUNC: acc_base = $signed({acc_trunc, 12'b0});
			default:             acc_base = acc_q;
		endcase
	end

	assign acc_next = acc_base + $signed({{2{prod[29]}}, prod});

	assign u_in_range = !u_q[cwa_pkg::U_W-1] && (u_q[cwa_pkg::U_W-2:cwa_pkg::DAC_W] == '0);
	assign u_clamped  = u_in_range ? u_q[cwa_pkg::DAC_W-1:0] :
		(u_q[cwa_pkg::U_W-1] ? '0 : '1);

	assign emit_blocked = out_valid_q && !result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= cwa_pkg::PC_START;
			phase_step_q <= 16'd437;
			ref_high_q   <= 12'd1999;
			coef_b0_q    <= 16'sd4862;
			coef_b1_q    <= -16'sd5878;
			coef_b2_q    <= 16'sd1778;
			awu_b0_q     <= 16'sd4764;
			awu_b1_q     <= -16'sd1741;
			phase_q      <= '0;
			err_prev_q   <= '0;
			err_prev2_q  <= '0;
			ctrl_prev_q  <= '0;
			adc_q        <= '0;
			scaled_q     <= '0;
			err_q        <= '0;
			acc_q        <= '0;
			u_q          <= '0;
			awu_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_dac_q    <= '0;
			out_awu_q    <= 1'b0;
			out_clip_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cwa_pkg::REG_PHASE_STEP: phase_step_q <= cfg_wdata;
					cwa_pkg::REG_REF_HIGH:   ref_high_q   <= cfg_wdata[cwa_pkg::REF_W-1:0];
					cwa_pkg::REG_COEF_B0:    coef_b0_q    <= $signed(cfg_wdata);
					cwa_pkg::REG_COEF_B1:    coef_b1_q    <= $signed(cfg_wdata);
					cwa_pkg::REG_COEF_B2:    coef_b2_q    <= $signed(cfg_wdata);
					cwa_pkg::REG_AWU_B0:     awu_b0_q     <= $signed(cfg_wdata);
					cwa_pkg::REG_AWU_B1:     awu_b1_q     <= $signed(cfg_wdata);
					default: ;
				endcase
			end

			if (cw.op == cwa_pkg::OP_EMIT && !emit_blocked) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (cw.op)
				cwa_pkg::OP_WAIT: begin
					if (sample_ch.valid) begin
						adc_q <= sample_ch.adc_sample;
						awu_q <= 1'b0;
						pc_q  <= pc_q + 4'd1;
					end
				end
				cwa_pkg::OP_SCALE: begin
					scaled_q <= adc_x129[17:3];
					pc_q     <= pc_q + 4'd1;
				end
				cwa_pkg::OP_ERROR: begin
					err_q <= err_new;
					pc_q  <= pc_q + 4'd1;
				end
				cwa_pkg::OP_MAC: begin
					acc_q <= acc_next;
					pc_q  <= pc_q + 4'd1;
				end
				cwa_pkg::OP_TRUNC: begin
					u_q  <= acc_trunc;
					pc_q <= pc_q + 4'd1;
				end
				cwa_pkg::OP_BRANCH: begin
					if (u_in_range) begin
						pc_q <= cw.target;
					end else begin
						awu_q <= 1'b1;
						pc_q  <= pc_q + 4'd1;
					end
				end
				cwa_pkg::OP_EMIT: begin
					// hold here while the previous word is still unclaimed
					if (!emit_blocked) begin
						out_dac_q   <= u_clamped;
						out_awu_q   <= awu_q;
						out_clip_q  <= !u_in_range;
						err_prev2_q <= err_prev_q;
						err_prev_q  <= err_q;
						ctrl_prev_q <= u_clamped;
						phase_q     <= phase_q + phase_step_q;
						pc_q        <= cw.target;
					end
				end
				default: pc_q <= cwa_pkg::PC_START;
			endcase
		end
	end

endmodule
